// ----- rtl/sta_pkg.sv -----
// Shared constants, types and key map tables for the scan code decoder.
package sta_pkg;

	localparam int DEF_FIFO_DEPTH = 128;

	localparam logic [6:0] KEY_LSHIFT = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT = 7'h36;
	localparam logic [6:0] KEY_CAPS   = 7'h3A;
	localparam logic [6:0] KEY_CTRL   = 7'h1D;
	localparam logic [6:0] KEY_ALT    = 7'h38;

	localparam logic [6:0] CHR_LOWER_A = 7'h61;
	localparam logic [6:0] CHR_LOWER_Z = 7'h7A;

	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef struct packed {
		logic       push;
		logic [6:0] ch;
	} push_t;

	function automatic logic [6:0] plain_char(input logic [6:0] code);
		logic [6:0] c;
		c = 7'h00;
		unique case (code)
			7'd1:  c = 7'h1B;  7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;
			7'd5:  c = 7'h34;  7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;
			7'd9:  c = 7'h38;  7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2D;
			7'd13: c = 7'h3D;  7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h71;
			7'd17: c = 7'h77;  7'd18: c = 7'h65;  7'd19: c = 7'h72;  7'd20: c = 7'h74;
			7'd21: c = 7'h79;  7'd22: c = 7'h75;  7'd23: c = 7'h69;  7'd24: c = 7'h6F;
			7'd25: c = 7'h70;  7'd26: c = 7'h5B;  7'd27: c = 7'h5D;  7'd28: c = 7'h0A;
			7'd30: c = 7'h61;  7'd31: c = 7'h73;  7'd32: c = 7'h64;  7'd33: c = 7'h66;
			7'd34: c = 7'h67;  7'd35: c = 7'h68;  7'd36: c = 7'h6A;  7'd37: c = 7'h6B;
			7'd38: c = 7'h6C;  7'd39: c = 7'h3B;  7'd40: c = 7'h27;  7'd41: c = 7'h60;
			7'd43: c = 7'h5C;  7'd44: c = 7'h7A;  7'd45: c = 7'h78;  7'd46: c = 7'h63;
			7'd47: c = 7'h76;  7'd48: c = 7'h62;  7'd49: c = 7'h6E;  7'd50: c = 7'h6D;
			7'd51: c = 7'h2C;  7'd52: c = 7'h2E;  7'd53: c = 7'h2F;  7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] shift_char(input logic [6:0] code);
		logic [6:0] c;
		c = 7'h00;
		unique case (code)
			7'd1:  c = 7'h1B;  7'd2:  c = 7'h21;  7'd3:  c = 7'h40;  7'd4:  c = 7'h23;
			7'd5:  c = 7'h24;  7'd6:  c = 7'h25;  7'd7:  c = 7'h5E;  7'd8:  c = 7'h26;
			7'd9:  c = 7'h2A;  7'd10: c = 7'h28;  7'd11: c = 7'h29;  7'd12: c = 7'h5F;
			7'd13: c = 7'h2B;  7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h51;
			7'd17: c = 7'h57;  7'd18: c = 7'h45;  7'd19: c = 7'h52;  7'd20: c = 7'h54;
			7'd21: c = 7'h59;  7'd22: c = 7'h55;  7'd23: c = 7'h49;  7'd24: c = 7'h4F;
			7'd25: c = 7'h50;  7'd26: c = 7'h7B;  7'd27: c = 7'h7D;  7'd28: c = 7'h0A;
			7'd30: c = 7'h41;  7'd31: c = 7'h53;  7'd32: c = 7'h44;  7'd33: c = 7'h46;
			7'd34: c = 7'h47;  7'd35: c = 7'h48;  7'd36: c = 7'h4A;  7'd37: c = 7'h4B;
			7'd38: c = 7'h4C;  7'd39: c = 7'h3A;  7'd40: c = 7'h22;  7'd41: c = 7'h7E;
			7'd43: c = 7'h7C;  7'd44: c = 7'h5A;  7'd45: c = 7'h58;  7'd46: c = 7'h43;
			7'd47: c = 7'h56;  7'd48: c = 7'h42;  7'd49: c = 7'h4E;  7'd50: c = 7'h4D;
			7'd51: c = 7'h3C;  7'd52: c = 7'h3E;  7'd53: c = 7'h3F;  7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/scancode_to_ascii_fifo_unit.sv -----
// Top level of the set 1 scan code decoder with character FIFO.
// Takes one transaction per cycle unless in_stall is high: a scan code byte (opcode 0) updates
// the shift and caps lock flags or maps a key press to a character that goes into a ring buffer
// of FIFO_DEPTH entries (FIFO_DEPTH-1 usable; a character that finds it full is dropped); a read
// (opcode 1) returns the oldest character or char_valid 0 when empty. A read result passes through
// the synchronous buffer memory read register and then the output register. Scan bytes produce
// no result. in_stall rises only while the output register is held by out_stall and a read result
// is waiting behind it.
module scancode_to_ascii_fifo_unit #(
	parameter int FIFO_DEPTH = sta_pkg::DEF_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       char_valid,
	output logic [6:0] ascii_char
);
	import sta_pkg::*;

	logic  in_acc;
	logic  scan_en;
	logic  rd_req;
	logic  busy;
	push_t push;

	assign in_stall = busy;
	assign in_acc   = in_valid && !busy;
	assign scan_en  = in_acc && (opcode == OP_SCAN);
	assign rd_req   = in_acc && (opcode == OP_READ);

	sta_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_en   (scan_en),
		.scan_byte (scan_byte),
		.push      (push)
	);

	sta_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rd_req     (rd_req),
		.out_stall  (out_stall),
		.busy       (busy),
		.out_valid  (out_valid),
		.char_valid (char_valid),
		.ascii_char (ascii_char)
	);

endmodule

// ----- rtl/sta_decode.sv -----
// Modifier tracking and scan code to character mapping.
module sta_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          scan_en,
	input  logic [7:0]    scan_byte,
	output sta_pkg::push_t push
);
	import sta_pkg::*;

	logic       shift_q;
	logic       caps_q;
	logic       release_key;
	logic [6:0] code;
	logic [6:0] base;
	logic       letter;
	logic       upper_sel;
	logic [6:0] ch;
	logic       is_shift;
	logic       is_mod;

	always_comb begin
		release_key = scan_byte[7];
		code        = scan_byte[6:0];
		is_shift    = (code == KEY_LSHIFT) || (code == KEY_RSHIFT);
		is_mod      = is_shift || (code == KEY_CAPS) || (code == KEY_CTRL) || (code == KEY_ALT);
		base        = plain_char(code);
		letter      = (base >= CHR_LOWER_A) && (base <= CHR_LOWER_Z);
		upper_sel   = shift_q ^ (caps_q & letter);
		ch          = upper_sel ? shift_char(code) : base;
		push.push   = scan_en && !release_key && !is_mod && (ch != 7'h00);
		push.ch     = ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
		end else if (scan_en) begin
			if (is_shift) begin
				shift_q <= !release_key;
			end else if ((code == KEY_CAPS) && !release_key) begin
				caps_q <= !caps_q;
			end
		end
	end

endmodule

// ----- rtl/sta_fifo.sv -----
// Character ring buffer memory with read pipeline and output register.
module sta_fifo #(
	parameter int FIFO_DEPTH = sta_pkg::DEF_FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sta_pkg::push_t push,
	input  logic          rd_req,
	input  logic          out_stall,
	output logic          busy,
	output logic          out_valid,
	output logic          char_valid,
	output logic [6:0]    ascii_char
);
	import sta_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

	logic [6:0]       mem [FIFO_DEPTH];
	logic [6:0]       rdata_q;
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W-1:0] wr_next;
	logic [PTR_W-1:0] rd_next;
	logic             full;
	logic             empty;
	logic             do_wr;
	logic             do_rd;
	logic             valid_s1;
	logic             hit_s1;
	logic             adv_s1;
	logic             out_valid_q;
	logic             char_valid_q;
	logic [6:0]       ascii_q;

	always_comb begin
		wr_next = (wr_q == LAST) ? '0 : wr_q + 1'b1;
		rd_next = (rd_q == LAST) ? '0 : rd_q + 1'b1;
		full    = (wr_next == rd_q);
		empty   = (rd_q == wr_q);
		do_wr   = push.push && !full;
		do_rd   = rd_req && !empty;
		adv_s1  = valid_s1 && (!out_valid_q || !out_stall);
		busy    = valid_s1 && !adv_s1;
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_q] <= push.ch;
		end
		if (do_rd) begin
			rdata_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= wr_next;
			end
			if (do_rd) begin
				rd_q <= rd_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else if (rd_req) begin
			valid_s1 <= 1'b1;
			hit_s1   <= !empty;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			char_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q  <= 1'b1;
			char_valid_q <= hit_s1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ascii_q <= hit_s1 ? rdata_q : 7'h00;
		end
	end

	assign out_valid  = out_valid_q;
	assign char_valid = char_valid_q;
	assign ascii_char = ascii_q;

endmodule

// ----- rtl/sta_checker.sv -----
// Port level checks for the scan code decoder, bound to its top level.
module sta_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       opcode,
	input logic       out_valid,
	input logic       out_stall,
	input logic       char_valid,
	input logic [6:0] ascii_char
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_valid) && $stable(ascii_char))
		else $error("stalled result changed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> ascii_char == 7'h00)
		else $error("empty read carries a character");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && opcode, 2))
		else $error("result without a read two cycles before");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

endmodule

bind scancode_to_ascii_fifo_unit sta_checker u_sta_checker (.*);

// ----- test/tb_scancode_to_ascii_fifo_unit.sv -----
// Testbench for the scan code decoder: driver, monitor and keystroke predictor with a char FIFO.
module tb_scancode_to_ascii_fifo_unit;
	import sta_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIFO_DEPTH = DEF_FIFO_DEPTH;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAP_TOP = 57;
	localparam logic [7:0] REL_BIT = 8'h80;

	localparam logic [6:0] UNSHIFTED_MAP [0:MAP_TOP] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	localparam logic [6:0] SHIFTED_MAP [0:MAP_TOP] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	typedef struct packed {
		opcode_t    op;
		logic [7:0] sb;
	} key_txn_t;

	typedef struct packed {
		logic       cv;
		logic [6:0] ch;
	} char_read_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       opcode = OP_SCAN;
	logic [7:0] scan_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       char_valid;
	logic [6:0] ascii_char;

	key_txn_t   key_txn_q[$];
	char_read_t char_read_q[$];
	logic [6:0] typed_char_q[$];

	logic shift_down = 1'b0;
	logic caps_lock = 1'b0;
	logic in_took = 1'b0;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   err_cnt = 0;
	int   cycle_cnt = 0;

	scancode_to_ascii_fifo_unit #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.scan_byte(scan_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_valid(char_valid),
		.ascii_char(ascii_char)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic track_keystroke(input opcode_t op, input logic [7:0] sb);
		logic [6:0] code;
		logic [6:0] ch;
		logic       is_rel;
		logic       letter;
		char_read_t res;
		code = sb[6:0];
		is_rel = sb[7];
		if (op == OP_READ) begin
			if (typed_char_q.size() == 0) begin
				res = '{1'b0, 7'h00};
			end else begin
				res = '{1'b1, typed_char_q.pop_front()};
			end
			char_read_q.push_back(res);
		end else if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
			shift_down = !is_rel;
		end else if (code == KEY_CAPS) begin
			if (!is_rel) begin
				caps_lock = !caps_lock;
			end
		end else if (!is_rel && code != KEY_CTRL && code != KEY_ALT && int'(code) <= MAP_TOP) begin
			ch = UNSHIFTED_MAP[code[5:0]];
			letter = (ch >= CHR_LOWER_A) && (ch <= CHR_LOWER_Z);
			if (shift_down ^ (caps_lock && letter)) begin
				ch = SHIFTED_MAP[code[5:0]];
			end
			if (ch != 7'h00 && typed_char_q.size() < FIFO_DEPTH - 1) begin
				typed_char_q.push_back(ch);
			end
		end
	endtask

	// monitor: check results, then predict accepted transactions
	always @(posedge clk) begin
		char_read_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (char_read_q.size() == 0) begin
					err_cnt++;
					if (err_cnt < 200) begin
						$display("%0t: unexpected result char_valid %0b ascii_char %h",
							$time, char_valid, ascii_char);
					end
				end else begin
					want = char_read_q.pop_front();
					if (char_valid !== want.cv) begin
						err_cnt++;
						if (err_cnt < 200) begin
							$display("%0t: char_valid expected %0b actual %0b",
								$time, want.cv, char_valid);
						end
					end
					if (ascii_char !== want.ch) begin
						err_cnt++;
						if (err_cnt < 200) begin
							$display("%0t: ascii_char expected %h actual %h",
								$time, want.ch, ascii_char);
						end
					end
				end
			end
			in_took = in_valid && !in_stall;
			if (in_took) begin
				track_keystroke(opcode_t'(opcode), scan_byte);
			end
		end
	end

	// driver: advance to the next transaction once the current one is taken
	always @(negedge clk) begin
		key_txn_t nxt;
		if (arst_n && (!in_valid || in_took)) begin
			if (key_txn_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = key_txn_q.pop_front();
				in_valid <= 1'b1;
				opcode <= nxt.op;
				scan_byte <= nxt.sb;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall, or a long hold when requested
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_scancode_to_ascii_fifo_unit: FAIL");
			$finish;
		end
	end

	task automatic queue_key(input opcode_t op, input logic [7:0] sb);
		key_txn_t t;
		t.op = op;
		t.sb = sb;
		key_txn_q.push_back(t);
	endtask

	task automatic queue_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 38) begin
				queue_key(OP_READ, 8'($urandom_range(255)));
			end else if (r < 73) begin
				queue_key(OP_SCAN, {1'b0, 7'($urandom_range(MAP_TOP))});
			end else if (r < 83) begin
				case ($urandom_range(2))
					0: queue_key(OP_SCAN, {1'($urandom_range(1)), KEY_LSHIFT});
					1: queue_key(OP_SCAN, {1'($urandom_range(1)), KEY_RSHIFT});
					default: queue_key(OP_SCAN, {1'($urandom_range(1)), KEY_CAPS});
				endcase
			end else if (r < 90) begin
				queue_key(OP_SCAN, REL_BIT | 8'($urandom_range(127)));
			end else begin
				queue_key(OP_SCAN, 8'($urandom_range(255)));
			end
		end
	endtask

	task automatic start_phase(input int send_pct, input int stall_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic wait_drain();
		while (key_txn_q.size() != 0 || in_valid || char_read_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		start_phase(0, 0);
		queue_key(OP_READ, 8'h55);
		queue_key(OP_SCAN, 8'h1E);
		queue_key(OP_SCAN, 8'h2A);
		queue_key(OP_SCAN, 8'h1E);
		queue_key(OP_SCAN, 8'hAA);
		queue_key(OP_SCAN, 8'h36);
		queue_key(OP_SCAN, 8'h02);
		queue_key(OP_SCAN, 8'hB6);
		queue_key(OP_SCAN, 8'h3A);
		queue_key(OP_SCAN, 8'hBA);
		queue_key(OP_SCAN, 8'h1E);
		queue_key(OP_SCAN, 8'h02);
		queue_key(OP_SCAN, 8'h2A);
		queue_key(OP_SCAN, 8'h1E);
		queue_key(OP_SCAN, 8'h1D);
		queue_key(OP_SCAN, 8'hB8);
		queue_key(OP_SCAN, 8'h9E);
		queue_key(OP_SCAN, 8'h00);
		queue_key(OP_SCAN, 8'hFF);
		for (int i = 0; i < 7; i++) begin
			queue_key(OP_READ, 8'($urandom_range(255)));
		end
		queue_random(240);
		wait_drain();

		// overfill the buffer, then drain it past empty
		start_phase(60, 0);
		for (int i = 0; i < 140; i++) begin
			queue_key(OP_SCAN, {1'b0, 7'($urandom_range(2, 13))});
		end
		for (int i = 0; i < 135; i++) begin
			queue_key(OP_READ, 8'($urandom_range(255)));
		end
		queue_random(240);
		wait_drain();

		start_phase(0, 60);
		queue_random(240);
		wait_drain();

		start_phase(21, 21);
		queue_random(240);
		wait_drain();

		// hold the output while reads pile up behind it
		start_phase(0, 0);
		hold_req = 1'b1;
		for (int i = 0; i < 60; i++) begin
			queue_key(OP_SCAN, {1'b0, 7'($urandom_range(16, 25))});
		end
		queue_random(100);
		wait_drain();

		repeat (6) @(negedge clk);
		if (err_cnt == 0) begin
			$display("tb_scancode_to_ascii_fifo_unit: PASS");
		end else begin
			$display("tb_scancode_to_ascii_fifo_unit: FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sta_pkg.sv
rtl/sta_decode.sv
rtl/sta_fifo.sv
rtl/scancode_to_ascii_fifo_unit.sv
rtl/sta_checker.sv
test/tb_scancode_to_ascii_fifo_unit.sv
